>>> hw/rtl/swlfs_pkg.sv
// ----------------------------------------------------------------------------
// swlfs_pkg
// Shared types and constants for the single-wire LED frame serialiser:
// bit phases, register indexes, register reset values and the
// configuration and result records passed between modules.
// ----------------------------------------------------------------------------
package swlfs_pkg;

    // widths of the item fields
    localparam int unsigned GRAY_W  = 12;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned FRAME_W = 48;
    localparam int unsigned BITS_W  = 6;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WORD_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_WORD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EOS_TICKS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_TICKS  = 3'd5;

    // register reset values
    localparam logic              RST_WORD_MODE    = 1'b0;
    localparam logic [GRAY_W-1:0] RST_COMMAND_WORD = 12'd938;
    localparam logic [TICK_W-1:0] RST_PULSE_TICKS  = 16'd1;
    localparam logic [TICK_W-1:0] RST_GAP_TICKS    = 16'd4;
    localparam logic [TICK_W-1:0] RST_EOS_TICKS    = 16'd35;
    localparam logic [TICK_W-1:0] RST_LATCH_TICKS  = 16'd105;

    // request kinds
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // word mode codes
    localparam logic MODE_12BIT = 1'b0;

    // bit counts per frame
    localparam logic [BITS_W-1:0] BITS_12BIT = 6'd48;
    localparam logic [BITS_W-1:0] BITS_8BIT  = 6'd32;

    // shortest phase length
    localparam logic [TICK_W-1:0] MIN_TICKS = 16'h0001;

    // phases of one bit and of the frame end
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_HIGH = 6'b000010,
        PH_LOW  = 6'b000100,
        PH_DATA = 6'b001000,
        PH_GAP  = 6'b010000,
        PH_END  = 6'b100000
    } phase_t;

    // configuration registers
    typedef struct packed {
        logic              word_mode;
        logic [GRAY_W-1:0] command_word;
        logic [TICK_W-1:0] pulse_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [TICK_W-1:0] eos_ticks;
        logic [TICK_W-1:0] latch_ticks;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } result_t;

endpackage

>>> hw/rtl/swlfs_core.sv
// ----------------------------------------------------------------------------
// swlfs_core
// Frame state and bit-phase sequencer. Works out the result of one item
// from the current state and updates the state when the item is stepped.
// ----------------------------------------------------------------------------
module swlfs_core
    import swlfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              req_type,
    input  logic              end_of_sequence,
    input  logic [GRAY_W-1:0] gray_a,
    input  logic [GRAY_W-1:0] gray_b,
    input  logic [GRAY_W-1:0] gray_c,
    input  cfg_t              cfg,
    output result_t           res
);

    phase_t               phase_reg, phase_next;
    logic [FRAME_W-1:0]   shift_reg, shift_next;
    logic [BITS_W-1:0]    bits_left_reg, bits_left_next;
    logic [TICK_W-1:0]    ticks_reg, ticks_next;
    logic                 eos_gap_reg, eos_gap_next;

    logic [TICK_W-1:0]    raw_len;
    logic [TICK_W-1:0]    phase_len;
    logic [TICK_W:0]      ticks_inc;
    logic                 phase_over;
    logic [BITS_W-1:0]    bits_dec;
    logic                 level;
    logic                 done;
    logic                 rej;

    // length of the current phase, zero counts as one
    always_comb begin
        unique case (phase_reg)
            PH_HIGH, PH_LOW, PH_DATA: raw_len = cfg.pulse_ticks;
            PH_GAP:                   raw_len = cfg.gap_ticks;
            default:                  raw_len = eos_gap_reg ? cfg.eos_ticks
                                                            : cfg.latch_ticks;
        endcase
        phase_len = (raw_len == '0) ? MIN_TICKS : raw_len;
    end

    // tick count, a wrap past the counter width also ends the phase
    assign ticks_inc  = {1'b0, ticks_reg} + {{TICK_W{1'b0}}, 1'b1};
    assign phase_over = (ticks_inc >= {1'b0, phase_len});
    assign bits_dec   = (bits_left_reg != '0) ? bits_left_reg - 6'd1 : bits_left_reg;

    // line level of this tick
    always_comb begin
        unique case (phase_reg)
            PH_HIGH: level = 1'b1;
            PH_DATA: level = shift_reg[FRAME_W-1];
            default: level = 1'b0;
        endcase
    end

    // next state and result flags
    always_comb begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        ticks_next     = ticks_reg;
        eos_gap_next   = eos_gap_reg;
        done           = 1'b0;
        rej            = 1'b0;
        if (req_type == REQ_FRAME) begin
            if (phase_reg != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                // words are aligned to the top so the next bit is always the msb
                if (cfg.word_mode == MODE_12BIT) begin
                    shift_next     = {cfg.command_word, gray_a, gray_b, gray_c};
                    bits_left_next = BITS_12BIT;
                end else begin
                    shift_next     = {cfg.command_word[7:0], gray_a[7:0],
                                      gray_b[7:0], gray_c[7:0], 16'h0000};
                    bits_left_next = BITS_8BIT;
                end
                eos_gap_next = end_of_sequence;
                phase_next   = PH_HIGH;
                ticks_next   = '0;
            end
        end else if (phase_reg != PH_IDLE) begin
            ticks_next = ticks_inc[TICK_W-1:0];
            if (phase_over) begin
                ticks_next = '0;
                unique case (phase_reg)
                    PH_HIGH: phase_next = PH_LOW;
                    PH_LOW:  phase_next = PH_DATA;
                    PH_DATA: phase_next = PH_GAP;
                    PH_GAP: begin
                        bits_left_next = bits_dec;
                        shift_next     = {shift_reg[FRAME_W-2:0], 1'b0};
                        phase_next     = (bits_dec == '0) ? PH_END : PH_HIGH;
                    end
                    default: begin
                        phase_next     = PH_IDLE;
                        shift_next     = '0;
                        bits_left_next = '0;
                        done           = 1'b1;
                    end
                endcase
            end
        end
    end

    assign res.line_level = (req_type == REQ_TICK) ? level : 1'b0;
    assign res.busy_res   = (phase_next != PH_IDLE);
    assign res.frame_done = done;
    assign res.rejected   = rej;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bits_left_reg <= '0;
            ticks_reg     <= '0;
            eos_gap_reg   <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            bits_left_reg <= bits_left_next;
            ticks_reg     <= ticks_next;
            eos_gap_reg   <= eos_gap_next;
        end
    end

    // frame data
    always_ff @(posedge aclk) begin
        if (step) begin
            shift_reg <= shift_next;
        end
    end

endmodule

>>> hw/rtl/single_wire_led_frame_serializer.sv
// ----------------------------------------------------------------------------
// single_wire_led_frame_serializer
// Serialiser for a one-wire LED driver line, paced by tick transactions.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: tuser 0 loads a frame (command word plus three grayscale
//   words from tdata), tuser 1 is one time tick. Every input transaction
//   gives exactly one result transaction on the m_ channel: tdata carries
//   the line level for that tick, the busy flag and the reject flag, and
//   tlast marks the tick that closes the end gap of a frame.
//   A frame sent while a frame is still running is dropped and flagged.
//   cfg_ channel: writes registers 0..5 (word mode, command word, pulse,
//   gap, end-of-sequence and latch tick counts); indexes 6 and 7 are
//   ignored. Write only while no frame is in progress.
//   Timing: one transaction per cycle is sustained while m_tready stays
//   high. A transaction is held in the input register, and its result is
//   loaded into the output register once that register is free or being
//   read, which raises m_tvalid.
//   If m_tready is low the output register holds; the input register still
//   takes one more transaction, then s_tready falls until the result goes.
//   Reset: line idle, registers at their reset values, both channels empty.
// ----------------------------------------------------------------------------
module single_wire_led_frame_serializer
    import swlfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,  // end_of_sequence, gray_a, gray_b, gray_c, pad
    input  logic                  s_tuser,  // req_type
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,  // line_level, busy_res, rejected, pad
    output logic                  m_tlast   // frame_done
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic              req_type_reg;
    logic              eos_reg;
    logic [GRAY_W-1:0] gray_a_reg;
    logic [GRAY_W-1:0] gray_b_reg;
    logic [GRAY_W-1:0] gray_c_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           res;
    logic              advance;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.word_mode    <= RST_WORD_MODE;
            cfg_reg.command_word <= RST_COMMAND_WORD;
            cfg_reg.pulse_ticks  <= RST_PULSE_TICKS;
            cfg_reg.gap_ticks    <= RST_GAP_TICKS;
            cfg_reg.eos_ticks    <= RST_EOS_TICKS;
            cfg_reg.latch_ticks  <= RST_LATCH_TICKS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WORD_MODE:    cfg_reg.word_mode    <= cfg_data[0];
                REG_COMMAND_WORD: cfg_reg.command_word <= cfg_data[GRAY_W-1:0];
                REG_PULSE_TICKS:  cfg_reg.pulse_ticks  <= cfg_data;
                REG_GAP_TICKS:    cfg_reg.gap_ticks    <= cfg_data;
                REG_EOS_TICKS:    cfg_reg.eos_ticks    <= cfg_data;
                REG_LATCH_TICKS:  cfg_reg.latch_ticks  <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake between input register and output register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_type_reg <= s_tuser;
            eos_reg      <= s_tdata[0];
            gray_a_reg   <= s_tdata[12:1];
            gray_b_reg   <= s_tdata[24:13];
            gray_c_reg   <= s_tdata[36:25];
        end
    end

    // frame sequencer
    swlfs_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .req_type        (req_type_reg),
        .end_of_sequence (eos_reg),
        .gray_a          (gray_a_reg),
        .gray_b          (gray_b_reg),
        .gray_c          (gray_c_reg),
        .cfg             (cfg_reg),
        .res             (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_reg.rejected, out_reg.busy_res, out_reg.line_level};
    assign m_tlast  = out_reg.frame_done;

endmodule

>>> tb/sv/swlfs_line_checker.sv
// ----------------------------------------------------------------------------
// swlfs_line_checker
// Watches the register, input and result channels of the single-wire LED
// frame serialiser, predicts the line level, busy, done and refused flags of
// every accepted input transaction and compares them in order with the
// result transactions that leave the block.
// ----------------------------------------------------------------------------
module swlfs_line_checker
    import swlfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [39:0]           s_tdata,  // end_of_sequence, gray_a, gray_b, gray_c, pad
    input  logic                  s_tuser,  // req_type
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,  // line_level, busy_res, rejected, pad
    input  logic                  m_tlast,  // frame_done
    input  logic                  end_of_run,
    output int unsigned           fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // own copy of the registers and of the line state
    cfg_t               regs;
    logic [FRAME_W-1:0] frame_word;
    logic [BITS_W-1:0]  bits_to_send;
    phase_t             line_phase;
    logic [TICK_W-1:0]  ticks_in_phase;
    logic               end_with_eos;
    logic               end_checked;

    // line results still owed by the block, oldest first
    result_t line_results_due[$];

    task automatic reset_line_model();
        regs.word_mode    = RST_WORD_MODE;
        regs.command_word = RST_COMMAND_WORD;
        regs.pulse_ticks  = RST_PULSE_TICKS;
        regs.gap_ticks    = RST_GAP_TICKS;
        regs.eos_ticks    = RST_EOS_TICKS;
        regs.latch_ticks  = RST_LATCH_TICKS;
        frame_word        = '0;
        bits_to_send      = '0;
        line_phase        = PH_IDLE;
        ticks_in_phase    = '0;
        end_with_eos      = 1'b0;
        end_checked       = 1'b0;
        fail_count        = 0;
        line_results_due.delete();
    endtask

    // a programmed duration of zero lasts one tick
    function automatic logic [TICK_W-1:0] ticks_or_one(input logic [TICK_W-1:0] n);
        return (n == '0) ? MIN_TICKS : n;
    endfunction

    // length of the phase the line is in now
    function automatic logic [TICK_W-1:0] phase_span();
        case (line_phase)
            PH_HIGH, PH_LOW, PH_DATA: return ticks_or_one(regs.pulse_ticks);
            PH_GAP:                   return ticks_or_one(regs.gap_ticks);
            default: return ticks_or_one(end_with_eos ? regs.eos_ticks : regs.latch_ticks);
        endcase
    endfunction

    // one input transaction: update the line state and give the expected result
    function automatic result_t advance_line(input logic kind, input logic [39:0] payload);
        result_t            r;
        logic [GRAY_W-1:0]  ga;
        logic [GRAY_W-1:0]  gb;
        logic [GRAY_W-1:0]  gc;
        logic [GRAY_W-1:0]  cmd;
        r   = '0;
        ga  = payload[12:1];
        gb  = payload[24:13];
        gc  = payload[36:25];
        cmd = regs.command_word;
        if (kind == REQ_FRAME) begin
            if (line_phase != PH_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                if (regs.word_mode == MODE_12BIT) begin
                    frame_word   = {cmd, ga, gb, gc};
                    bits_to_send = BITS_12BIT;
                end else begin
                    frame_word   = {16'h0000, cmd[7:0], ga[7:0], gb[7:0], gc[7:0]};
                    bits_to_send = BITS_8BIT;
                end
                end_with_eos   = payload[0];
                line_phase     = PH_HIGH;
                ticks_in_phase = '0;
            end
        end else if (line_phase != PH_IDLE) begin
            case (line_phase)
                PH_HIGH: r.line_level = 1'b1;
                PH_DATA: r.line_level = (bits_to_send != '0) ?
                                        frame_word[bits_to_send - 1'b1] : 1'b0;
                default: r.line_level = 1'b0;
            endcase
            ticks_in_phase = ticks_in_phase + 1'b1;
            if (ticks_in_phase >= phase_span() || ticks_in_phase == '0) begin
                ticks_in_phase = '0;
                case (line_phase)
                    PH_HIGH: line_phase = PH_LOW;
                    PH_LOW:  line_phase = PH_DATA;
                    PH_DATA: line_phase = PH_GAP;
                    PH_GAP: begin
                        if (bits_to_send != '0)
                            bits_to_send = bits_to_send - 1'b1;
                        line_phase = (bits_to_send == '0) ? PH_END : PH_HIGH;
                    end
                    default: begin
                        line_phase   = PH_IDLE;
                        frame_word   = '0;
                        bits_to_send = '0;
                        r.frame_done = 1'b1;
                    end
                endcase
            end
        end
        r.busy_res = (line_phase != PH_IDLE);
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic check_flag(input string name, input logic due, input logic seen);
        if (seen !== due)
            flag_mismatch($sformatf("%s expected %b, got %b", name, due, seen));
    endtask

    // sample all three channels at the clock edge
    always @(posedge aclk) begin : watch_channels
        result_t seen;
        result_t due;
        if (!aresetn) begin
            reset_line_model();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WORD_MODE:    regs.word_mode    = cfg_data[0];
                    REG_COMMAND_WORD: regs.command_word = cfg_data[GRAY_W-1:0];
                    REG_PULSE_TICKS:  regs.pulse_ticks  = cfg_data;
                    REG_GAP_TICKS:    regs.gap_ticks    = cfg_data;
                    REG_EOS_TICKS:    regs.eos_ticks    = cfg_data;
                    REG_LATCH_TICKS:  regs.latch_ticks  = cfg_data;
                    default: ;
                endcase
            end
            // result transactions against the oldest prediction
            if (m_tvalid && m_tready) begin
                seen.line_level = m_tdata[0];
                seen.busy_res   = m_tdata[1];
                seen.rejected   = m_tdata[2];
                seen.frame_done = m_tlast;
                if (line_results_due.size() == 0) begin
                    flag_mismatch($sformatf("result %b with nothing outstanding", seen));
                end else begin
                    due = line_results_due.pop_front();
                    check_flag("line_level", due.line_level, seen.line_level);
                    check_flag("busy_res",   due.busy_res,   seen.busy_res);
                    check_flag("frame_done", due.frame_done, seen.frame_done);
                    check_flag("rejected",   due.rejected,   seen.rejected);
                end
            end
            // input transactions
            if (s_tvalid && s_tready)
                line_results_due.push_back(advance_line(s_tuser, s_tdata));
            // anything still owed at the end is lost
            if (end_of_run && !end_checked) begin
                end_checked = 1'b1;
                if (line_results_due.size() != 0)
                    flag_mismatch($sformatf("%0d results never arrived",
                                            line_results_due.size()));
            end
        end
    end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the single-wire LED frame serialiser: directed frames at the
// register extremes, zero durations and refused frames, then random register
// settings with random frames, ticks, input pauses and result back-pressure.
// Prediction and comparison live in swlfs_line_checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swlfs_pkg::*;

    // random frames are started until this many transactions have gone in
    localparam int unsigned ITEM_TARGET  = 1300;
    localparam int unsigned IDLE_PCT     = 38;
    localparam int unsigned CYCLE_LIMIT  = 100_000;

    // indexes past the register list, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic                 MODE_8BIT    = ~MODE_12BIT;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  s_tvalid   = 1'b0;
    logic [39:0]           s_tdata    = '0;
    logic                  s_tuser    = REQ_TICK;
    logic                  m_tready   = 1'b0;
    logic                  end_of_run = 1'b0;
    wire                   cfg_ready;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [7:0]            m_tdata;
    wire                   m_tlast;
    int unsigned           fail_count;

    bit          steady             = 1'b0;
    logic        line_busy          = 1'b0;
    int unsigned items_sent         = 0;
    int unsigned results_seen       = 0;
    int unsigned frames_done        = 0;
    int unsigned frames_turned_away = 0;
    int unsigned settings_used      = 0;
    int unsigned cycle_count        = 0;

    always #10 aclk = ~aclk;

    single_wire_led_frame_serializer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    swlfs_line_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .end_of_run (end_of_run),
        .fail_count (fail_count)
    );

    // result side: random back-pressure and a running tally
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        if (m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            line_busy    <= m_tdata[1];
            if (m_tlast)
                frames_done <= frames_done + 1;
            if (m_tdata[2])
                frames_turned_away <= frames_turned_away + 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [39:0] frame_payload(input logic eos, input logic [GRAY_W-1:0] ga,
                                                  input logic [GRAY_W-1:0] gb,
                                                  input logic [GRAY_W-1:0] gc);
        return {3'b000, gc, gb, ga, eos};
    endfunction

    function automatic logic [39:0] any_payload();
        return frame_payload(1'($urandom_range(0, 1)), GRAY_W'($urandom_range(0, 4095)),
                             GRAY_W'($urandom_range(0, 4095)),
                             GRAY_W'($urandom_range(0, 4095)));
    endfunction

    task automatic idle_cycle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // one input transaction, after a random pause
    task automatic send_item(input logic kind, input logic [39:0] payload);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
            idle_cycle();
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic mode, input logic [GRAY_W-1:0] cmd,
                             input logic [TICK_W-1:0] pulse, input logic [TICK_W-1:0] gap,
                             input logic [TICK_W-1:0] eos, input logic [TICK_W-1:0] latch);
        write_reg(REG_WORD_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
        write_reg(REG_COMMAND_WORD, {{(CFG_DATA_W-GRAY_W){1'b0}}, cmd});
        write_reg(REG_PULSE_TICKS, pulse);
        write_reg(REG_GAP_TICKS, gap);
        write_reg(REG_EOS_TICKS, eos);
        write_reg(REG_LATCH_TICKS, latch);
        settings_used++;
    endtask

    // tick the line until the frame has ended and every result is back,
    // now and then throwing in a frame that should be refused
    task automatic run_out(input int unsigned refuse_pct);
        while (line_busy || items_sent != results_seen) begin
            if (line_busy) begin
                if ($urandom_range(0, 99) < refuse_pct)
                    send_item(REQ_FRAME, any_payload());
                else
                    send_item(REQ_TICK, any_payload());
            end else begin
                idle_cycle();
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ticks while idle change nothing
        send_item(REQ_TICK, any_payload());
        send_item(REQ_TICK, frame_payload(1'b1, '1, '1, '1));
        run_out(0);

        // reset settings: all-ones grayscale words, then a frame refused while busy;
        // both sides run without a pause for the whole frame
        steady = 1'b1;
        send_item(REQ_FRAME, frame_payload(1'b1, 12'hFFF, 12'hFFF, 12'hFFF));
        send_item(REQ_FRAME, frame_payload(1'b0, 12'h000, 12'h000, 12'h000));
        run_out(0);
        steady = 1'b0;

        // zero durations act as one tick; 8-bit words, all-ones command
        configure(MODE_8BIT, 12'hFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(REQ_FRAME, frame_payload(1'b0, 12'h000, 12'hF0F, 12'h0F0));
        run_out(0);
        send_item(REQ_FRAME, frame_payload(1'b1, 12'h3C5, 12'hFFF, 12'h000));
        run_out(0);

        // writes past the register list are ignored
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        send_item(REQ_FRAME, frame_payload(1'b1, 12'h001, 12'h800, 12'h555));
        run_out(0);

        // longest pulse and gap are taken by the registers, idle ticks only
        write_reg(REG_PULSE_TICKS, 16'hFFFF);
        write_reg(REG_GAP_TICKS, 16'hFFFF);
        send_item(REQ_TICK, any_payload());
        run_out(0);

        // long end gaps, one for each frame ending
        configure(MODE_12BIT, 12'h000, 16'd1, 16'd1, 16'd60, 16'd1);
        send_item(REQ_FRAME, frame_payload(1'b1, 12'hA5A, 12'h5A5, 12'h000));
        run_out(1);
        configure(MODE_8BIT, 12'h5A5, 16'd1, 16'd1, 16'd1, 16'd60);
        send_item(REQ_FRAME, frame_payload(1'b0, 12'hFFF, 12'h000, 12'hA5A));
        run_out(1);

        // random settings, each followed by a few frames
        while (items_sent < ITEM_TARGET) begin
            configure(1'($urandom_range(0, 1)), GRAY_W'($urandom_range(0, 4095)),
                      TICK_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3)),
                      TICK_W'($urandom_range(0, 5)), TICK_W'($urandom_range(0, 40)),
                      TICK_W'($urandom_range(0, 60)));
            repeat ($urandom_range(1, 3)) begin
                if (items_sent < ITEM_TARGET) begin
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 4)) send_item(REQ_TICK, any_payload());
                    send_item(REQ_FRAME, any_payload());
                    run_out(4);
                end
            end
        end

        // everything is back; let the checker see end_of_run before the verdict
        end_of_run <= 1'b1;
        repeat (8) @(posedge aclk);
        $display("%0d input transactions, %0d frames finished, %0d frames refused while busy",
                 items_sent, frames_done, frames_turned_away);
        $display("%0d register settings, both word modes, zero and full-scale register values",
                 settings_used);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
